// ===== hw/rtl/bfhs_pkg.sv =====
// Package for the back/forward history stacks.
// Holds shared defaults, field widths, opcode and status codes and the stack control struct.
// No dependencies.
package bfhs_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int PAGE_BITS_DEF   = 16;

    localparam int OPCODE_W = 2;
    localparam int PAGE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_VISIT   = 2'd0,
        OP_BACK    = 2'd1,
        OP_FORWARD = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_BACK_EMPTY  = 2'd1,
        ST_FWD_EMPTY   = 2'd2,
        ST_PUSH_DROP   = 2'd3
    } t_status;

    // Per-cycle command to one stack
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stack_ctl;

endpackage

// ===== hw/rtl/bfhs_cell.sv =====
// One entry of a shift stack: takes the entry above on push, below on pop.
// Depends on bfhs_pkg.
module bfhs_cell #(
    parameter int WIDTH = bfhs_pkg::PAGE_BITS_DEF
) (
    input  logic                  i_clk,
    input  bfhs_pkg::t_stack_ctl  i_ctl,
    input  logic [WIDTH-1:0]      i_above,
    input  logic [WIDTH-1:0]      i_below,
    output logic [WIDTH-1:0]      o_entry
);
    import bfhs_pkg::*;

    logic [WIDTH-1:0] r_entry;
    logic [WIDTH-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            n_entry = i_above;
        end else if (i_ctl.pop) begin
            n_entry = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== hw/rtl/bfhs_stack.sv =====
// Shift stack built from a chain of bfhs_cell plus an occupancy counter.
// Depends on bfhs_pkg and bfhs_cell.
module bfhs_stack #(
    parameter int DEPTH = bfhs_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = bfhs_pkg::PAGE_BITS_DEF,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bfhs_pkg::t_stack_ctl  i_ctl,
    input  logic [WIDTH-1:0]      i_push_data,
    output logic [WIDTH-1:0]      o_top,
    output logic [CW-1:0]         o_count,
    output logic                  o_full,
    output logic                  o_empty
);
    import bfhs_pkg::*;

    logic [WIDTH-1:0] entry [DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    // Cell 0 is the top; each cell shifts with its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] above;
        logic [WIDTH-1:0] below;
        if (g == 0) begin : g_top
            assign above = i_push_data;
        end else begin : g_mid
            assign above = entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_bot
            assign below = entry[g];
        end else begin : g_up
            assign below = entry[g+1];
        end
        bfhs_cell #(.WIDTH(WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_above (above),
            .i_below (below),
            .o_entry (entry[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top   = entry[0];
    assign o_count = r_count;
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ===== hw/rtl/back_forward_history_stacks.sv =====
// Top level of the back/forward navigation history.
// Two shift stacks (bfhs_stack) around a current-page register; depends on bfhs_pkg.
//
//  channel   | ports                                              | handshake
//  ----------+----------------------------------------------------+---------------------------
//  command   | i_opcode, i_page_id                                | start high, busy low
//  result    | o_current_page, o_status, o_back_count, o_forward_count | o_valid for one cycle
//  config    | i_cfg_wdata (home_page)                            | i_cfg_we, no wait
//
// One item per cycle: every step shifts each stack's cell chain by at most one place,
// so the next item is taken in the very next cycle and busy never rises.
// The result appears on the cycle after the item is taken, strobed by o_valid.
// Synchronous active-low reset empties both stacks and makes page 0 current; no clearing
// pass is needed since only entries below the counts are ever read.
// The receiver cannot stall: a result is shown for exactly one cycle.
module back_forward_history_stacks #(
    parameter int STACK_DEPTH = bfhs_pkg::STACK_DEPTH_DEF,
    parameter int PAGE_BITS   = bfhs_pkg::PAGE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [bfhs_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [bfhs_pkg::PAGE_W-1:0]     i_page_id,
    input  logic                            i_cfg_we,
    input  logic [bfhs_pkg::PAGE_W-1:0]     i_cfg_wdata,
    output logic                            o_valid,
    output logic [bfhs_pkg::PAGE_W-1:0]     o_current_page,
    output logic [bfhs_pkg::STATUS_W-1:0]   o_status,
    output logic [bfhs_pkg::COUNT_W-1:0]    o_back_count,
    output logic [bfhs_pkg::COUNT_W-1:0]    o_forward_count
);
    import bfhs_pkg::*;

    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int PXW = PAGE_BITS + PAGE_W;
    localparam int CXW = CW + COUNT_W;

    // Handle width conversion between the 16-bit ports and PAGE_BITS storage
    logic [PXW-1:0]       page_ext;
    logic [PXW-1:0]       cfg_ext;
    logic [PXW-1:0]       cur_ext;
    logic [PAGE_BITS-1:0] page_in;
    logic [PAGE_BITS-1:0] cfg_in;

    logic accept;

    t_stack_ctl           back_ctl;
    t_stack_ctl           fwd_ctl;
    logic [PAGE_BITS-1:0] back_top;
    logic [PAGE_BITS-1:0] fwd_top;
    logic [CW-1:0]        back_count;
    logic [CW-1:0]        fwd_count;
    logic                 back_full;
    logic                 back_empty;
    logic                 fwd_full;
    logic                 fwd_empty;

    logic [PAGE_BITS-1:0] r_cur;
    logic [PAGE_BITS-1:0] n_cur;
    logic                 r_stepped;
    logic                 r_valid;
    t_status              r_status;
    t_status              n_status;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign page_ext = {{PAGE_BITS{1'b0}}, i_page_id};
    assign cfg_ext  = {{PAGE_BITS{1'b0}}, i_cfg_wdata};
    assign page_in  = page_ext[PAGE_BITS-1:0];
    assign cfg_in   = cfg_ext[PAGE_BITS-1:0];

    // Step decode: decide pushes, pops and the new current page
    always_comb begin
        back_ctl = '0;
        fwd_ctl  = '0;
        n_status = ST_OK;
        n_cur    = r_cur;
        if (accept) begin
            case (t_opcode'(i_opcode))
                OP_VISIT: begin
                    // push current onto back (drop when full), empty forward
                    back_ctl.push = !back_full;
                    fwd_ctl.clear = 1'b1;
                    n_status      = back_full ? ST_PUSH_DROP : ST_OK;
                    n_cur         = page_in;
                end
                OP_BACK: begin
                    if (back_empty) begin
                        n_status = ST_BACK_EMPTY;
                    end else begin
                        fwd_ctl.push  = !fwd_full;
                        back_ctl.pop  = 1'b1;
                        n_status      = fwd_full ? ST_PUSH_DROP : ST_OK;
                        n_cur         = back_top;
                    end
                end
                OP_FORWARD: begin
                    if (fwd_empty) begin
                        n_status = ST_FWD_EMPTY;
                    end else begin
                        back_ctl.push = !back_full;
                        fwd_ctl.pop   = 1'b1;
                        n_status      = back_full ? ST_PUSH_DROP : ST_OK;
                        n_cur         = fwd_top;
                    end
                end
                default: begin
                    // unused code: leave state alone, report ok
                    n_status = ST_OK;
                end
            endcase
        end else if (i_cfg_we && !r_stepped) begin
            // home page becomes current until the first step
            n_cur = cfg_in;
        end
    end

    bfhs_stack #(.DEPTH(STACK_DEPTH), .WIDTH(PAGE_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (back_ctl),
        .i_push_data (r_cur),
        .o_top       (back_top),
        .o_count     (back_count),
        .o_full      (back_full),
        .o_empty     (back_empty)
    );

    bfhs_stack #(.DEPTH(STACK_DEPTH), .WIDTH(PAGE_BITS)) u_fwd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fwd_ctl),
        .i_push_data (r_cur),
        .o_top       (fwd_top),
        .o_count     (fwd_count),
        .o_full      (fwd_full),
        .o_empty     (fwd_empty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_stepped <= 1'b0;
            r_valid   <= 1'b0;
            r_status  <= ST_OK;
        end else begin
            r_cur    <= n_cur;
            r_valid  <= accept;
            r_status <= n_status;
            if (accept) begin
                r_stepped <= 1'b1;
            end
        end
    end

    // Result: counters and current page already hold the post-step state
    logic [CXW-1:0] back_cnt_ext;
    logic [CXW-1:0] fwd_cnt_ext;

    assign cur_ext      = {{PAGE_W{1'b0}}, r_cur};
    assign back_cnt_ext = {{COUNT_W{1'b0}}, back_count};
    assign fwd_cnt_ext  = {{COUNT_W{1'b0}}, fwd_count};

    assign o_valid         = r_valid;
    assign o_current_page  = cur_ext[PAGE_W-1:0];
    assign o_status        = r_status;
    assign o_back_count    = back_cnt_ext[COUNT_W-1:0];
    assign o_forward_count = fwd_cnt_ext[COUNT_W-1:0];

    // Every taken item yields a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("result strobe missing after an accepted item");

    // No result without an item taken the cycle before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_valid)
        else $error("result strobe without an accepted item");

    // An empty-history report leaves both counts untouched
    a_empty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_BACK_EMPTY || o_status == ST_FWD_EMPTY))
        |-> ($stable(back_count) && $stable(fwd_count)))
        else $error("counts moved on an empty-history step");

    // A visit always empties the forward history
    a_visit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_VISIT) |=> (fwd_count == '0))
        else $error("forward history not cleared by visit");

endmodule

// ===== verif/back_forward_history_stacks_tb.sv =====
// Self-checking testbench for back_forward_history_stacks: navigation items in, one result per item.
// Predicts each result from its own two-stack history model; depends on bfhs_pkg and the RTL top.
module back_forward_history_stacks_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfhs_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 306;

    typedef struct {
        t_opcode            op;
        logic [PAGE_W-1:0]  page;
    } t_nav_item;

    typedef struct {
        logic [PAGE_W-1:0]  page;
        t_status            status;
        logic [COUNT_W-1:0] back_n;
        logic [COUNT_W-1:0] fwd_n;
    } t_nav_view;

    // DUT connections; every input starts at a known value
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic [OPCODE_W-1:0] i_opcode    = '0;
    logic [PAGE_W-1:0]   i_page_id   = '0;
    logic                i_cfg_we    = 1'b0;
    logic [PAGE_W-1:0]   i_cfg_wdata = '0;
    logic                o_valid;
    logic [PAGE_W-1:0]   o_current_page;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_back_count;
    logic [COUNT_W-1:0]  o_forward_count;

    // Items waiting to be sent, and the results they are expected to produce
    t_nav_item pending_items[$];
    t_nav_view expected_views[$];

    int sender_idle_pct = 0;
    int mismatches      = 0;
    int results_seen    = 0;
    int cycle_count     = 0;

    // History model: two stacks around the current page
    logic [PAGE_W-1:0] back_hist[DEPTH];
    logic [PAGE_W-1:0] fwd_hist[DEPTH];
    int                back_depth_m = 0;
    int                fwd_depth_m  = 0;
    logic [PAGE_W-1:0] cur_page_m   = '0;
    bit                navigated    = 1'b0;

    back_forward_history_stacks i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_page_id       (i_page_id),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_current_page  (o_current_page),
        .o_status        (o_status),
        .o_back_count    (o_back_count),
        .o_forward_count (o_forward_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one navigation item to the model and return the state it leaves behind.
    function automatic t_nav_view navigate(t_opcode op, logic [PAGE_W-1:0] page);
        t_nav_view view;
        t_status   st;
        st        = ST_OK;
        navigated = 1'b1;
        case (op)
            OP_VISIT: begin
                // A full back history drops the push, but the visit still lands
                if (back_depth_m < DEPTH) begin
                    back_hist[back_depth_m] = cur_page_m;
                    back_depth_m++;
                end else begin
                    st = ST_PUSH_DROP;
                end
                fwd_depth_m = 0;
                cur_page_m  = page;
            end
            OP_BACK: begin
                if (back_depth_m == 0) begin
                    st = ST_BACK_EMPTY;
                end else begin
                    if (fwd_depth_m < DEPTH) begin
                        fwd_hist[fwd_depth_m] = cur_page_m;
                        fwd_depth_m++;
                    end else begin
                        st = ST_PUSH_DROP;
                    end
                    back_depth_m--;
                    cur_page_m = back_hist[back_depth_m];
                end
            end
            OP_FORWARD: begin
                if (fwd_depth_m == 0) begin
                    st = ST_FWD_EMPTY;
                end else begin
                    if (back_depth_m < DEPTH) begin
                        back_hist[back_depth_m] = cur_page_m;
                        back_depth_m++;
                    end else begin
                        st = ST_PUSH_DROP;
                    end
                    fwd_depth_m--;
                    cur_page_m = fwd_hist[fwd_depth_m];
                end
            end
            default: begin
                // Unused opcode: report the present state unchanged
            end
        endcase
        view.page   = cur_page_m;
        view.status = st;
        view.back_n = COUNT_W'(back_depth_m);
        view.fwd_n  = COUNT_W'(fwd_depth_m);
        return view;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("[%0t] result %0d: %s mismatch, got 0x%0h, want 0x%0h",
                 $realtime, results_seen, field, got, want);
        mismatches++;
    endtask

    // Driver: take the accepted item into the model, then offer the next one or idle.
    always @(posedge i_clk) begin
        t_nav_item nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_views.push_back(navigate(t_opcode'(i_opcode), i_page_id));
            end
            if (start && busy) begin
                // hold the item until the block takes it
            end else if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                nxt = pending_items.pop_front();
                start     <= 1'b1;
                i_opcode  <= nxt.op;
                i_page_id <= nxt.page;
            end else begin
                // Idle with junk on the payload so that start alone qualifies it
                start     <= 1'b0;
                i_opcode  <= OPCODE_W'($urandom_range(3));
                i_page_id <= PAGE_W'($urandom);
            end
        end
    end

    // Monitor: each strobed result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_nav_view want;
        if (i_rst_n && o_valid) begin
            if (expected_views.size() == 0) begin
                report_mismatch("unexpected result, page", o_current_page, 0);
            end else begin
                want = expected_views.pop_front();
                if (o_current_page !== want.page)
                    report_mismatch("current_page", o_current_page, want.page);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_back_count !== want.back_n)
                    report_mismatch("back_count", o_back_count, want.back_n);
                if (o_forward_count !== want.fwd_n)
                    report_mismatch("forward_count", o_forward_count, want.fwd_n);
            end
            results_seen++;
        end
    end

    // Watchdog: a hang or a lost result ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [PAGE_W-1:0] pick_page();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return PAGE_W'($urandom);
    endfunction

    task automatic add_item(t_opcode op, logic [PAGE_W-1:0] page);
        t_nav_item it;
        it.op   = op;
        it.page = page;
        pending_items.push_back(it);
    endtask

    // Queue random navigation: mostly runs of one operation so the stacks go deep,
    // with a little noise and the odd long burst of visits that overflows the back history.
    task automatic add_random_nav(int count, bit force_fill);
        int      added;
        int      run;
        int      r;
        bit      noise;
        t_opcode op;
        added = 0;
        if (force_fill) begin
            for (int k = 0; k < DEPTH + 3; k++)
                add_item(OP_VISIT, pick_page());
            added = DEPTH + 3;
        end
        while (added < count) begin
            r     = $urandom_range(99);
            noise = 1'b0;
            op    = OP_VISIT;
            if (r < 40) begin
                run = $urandom_range(1, 8);
            end else if (r < 64) begin
                run = $urandom_range(1, 10);
                op  = OP_BACK;
            end else if (r < 88) begin
                run = $urandom_range(1, 10);
                op  = OP_FORWARD;
            end else if (r < 92) begin
                run = 1;
                op  = OP_NONE;
            end else if (r < 97) begin
                run   = $urandom_range(1, 4);
                noise = 1'b1;
            end else begin
                run = DEPTH + $urandom_range(1, 6);
            end
            for (int k = 0; k < run; k++) begin
                if (noise)
                    add_item(t_opcode'($urandom_range(3)), pick_page());
                else
                    add_item(op, pick_page());
            end
            added += run;
        end
    endtask

    // Wait until every item is taken and every result checked, then let the pipe settle.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_items.size() != 0 || start || expected_views.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The home page loads the current page only until the first navigation item.
    task automatic write_home(logic [PAGE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (!navigated)
            cur_page_m = value;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Both extremes of the home page before any step; the last one is current
        write_home('0);
        write_home('1);
        @(negedge i_clk);

        // Directed walk: empty pops, extreme handles, return to home, forward cleared by visit
        sender_idle_pct = 0;
        add_item(OP_BACK,    '0);
        add_item(OP_FORWARD, '0);
        add_item(OP_NONE,    '1);
        add_item(OP_VISIT,   16'h0000);
        add_item(OP_VISIT,   16'hFFFF);
        add_item(OP_VISIT,   16'h8001);
        add_item(OP_BACK,    '1);
        add_item(OP_BACK,    '0);
        add_item(OP_BACK,    16'h1234);
        add_item(OP_BACK,    '0);
        add_item(OP_FORWARD, '1);
        add_item(OP_FORWARD, '0);
        add_item(OP_FORWARD, '0);
        add_item(OP_FORWARD, '0);
        add_item(OP_BACK,    '0);
        add_item(OP_VISIT,   16'h7FFE);
        add_item(OP_FORWARD, '0);
        add_item(OP_NONE,    '0);

        // Random phases; each boundary holds the sender until all results are in
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                wait_drained();
                case (ph)
                    1:       write_home(16'h8001);
                    2:       write_home(16'h0000);
                    3:       write_home(PAGE_W'($urandom));
                    default: write_home(16'hFFFF);
                endcase
                @(negedge i_clk);
            end
            case (ph)
                1, 4:    sender_idle_pct = 77;
                2:       sender_idle_pct = 18;
                default: sender_idle_pct = 0;
            endcase
            add_random_nav(PHASE_ITEMS, ph == 1);
        end

        wait_drained();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
